FILE: sv/key_value_slot_table_defines.svh
// ----------------------------------------------------------------------------
// Key/value slot table assertion macros
// Shared assertion helpers, compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_SLOT_TABLE_DEFINES_SVH
`define KEY_VALUE_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define KVST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KVST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KVST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define KVST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/kvst_pkg.sv
// ----------------------------------------------------------------------------
// Key/value slot table package
// Request/result types, the token that walks the slot chain, and codes.
// ----------------------------------------------------------------------------
package kvst_pkg;

    localparam int KEY_W  = 16;
    localparam int VAL_W  = 16;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  found_value;
    } t_resp;

    // One request in flight along the chain of slots.
    typedef struct packed {
        logic             active;
        logic             done;
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] found_value;
    } t_token;

endpackage

FILE: sv/kvst_cell.sv
// ----------------------------------------------------------------------------
// Key/value slot cell
// Holds one slot and acts on the request token as it passes to the next cell.
// ----------------------------------------------------------------------------
module kvst_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kvst_pkg::t_token i_tok,
    output kvst_pkg::t_token o_tok
);
    import kvst_pkg::*;

    logic             r_valid, n_valid;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_active;
    t_token           r_tok, n_tok;
    logic             w_match;

    assign w_match = r_valid && (r_key == i_tok.key);

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_key   = r_key;
        n_value = r_value;
        // first qualifying cell claims the transaction; later cells see done
        if (i_tok.active && !i_tok.done) begin
            unique case (i_tok.req_type)
                REQ_ADD: begin
                    if (!r_valid) begin
                        n_valid    = 1'b1;
                        n_key      = i_tok.key;
                        n_value    = i_tok.value;
                        n_tok.done = 1'b1;
                    end
                end
                REQ_REMOVE: begin
                    if (w_match) begin
                        n_valid    = 1'b0;
                        n_tok.done = 1'b1;
                    end
                end
                REQ_LOOKUP: begin
                    if (w_match) begin
                        n_tok.done        = 1'b1;
                        n_tok.found_value = r_value;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_active <= i_tok.active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_tok   <= n_tok;
    end

    always_comb begin
        o_tok        = r_tok;
        o_tok.active = r_active;
    end

endmodule

FILE: sv/key_value_slot_table.sv
// ----------------------------------------------------------------------------
// Key/value slot table
// Fixed table of 16-bit key/value pairs with add, remove and lookup.
// ----------------------------------------------------------------------------
// Each slot lives in its own cell, and the cells form a chain. An accepted
// request becomes a token that moves one cell per clock; the lowest free
// (add) or lowest matching (remove, lookup) cell claims it on the way. The
// result is registered into the output buffer as the token leaves the last
// cell, and no new request is accepted until the token has left the chain.
// A two-deep output buffer lets the next request start while a result is
// still waiting to be taken. Slot valid bits clear at reset; no init pass.
// ----------------------------------------------------------------------------
`include "key_value_slot_table_defines.svh"

module key_value_slot_table #(
    parameter int ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  kvst_pkg::t_req  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output kvst_pkg::t_resp o_out
);
    import kvst_pkg::*;

    t_token             w_tok [ENTRIES+1];
    t_token             w_head;
    logic [ENTRIES-1:0] w_act;

    logic  w_in_acc, w_exit, w_out_take;
    t_resp w_res;

    logic  r_busy, n_busy;
    logic  r_out_valid, n_out_valid;
    logic  r_pend_valid, n_pend_valid;
    t_resp r_out, n_out;
    t_resp r_pend, n_pend;

    assign o_in_ready = !r_busy && !r_pend_valid;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        w_head.active      = w_in_acc;
        w_head.done        = 1'b0;
        w_head.req_type    = i_in.req_type;
        w_head.key         = i_in.key;
        w_head.value       = i_in.value;
        w_head.found_value = '0;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
        assign w_act[g] = w_tok[g+1].active;
    end

    assign w_exit     = w_tok[ENTRIES].active;
    assign w_out_take = r_out_valid && i_out_ready;

    // Unclaimed add, remove or lookup token at chain end means full or not found; an unused code gives OK.
    always_comb begin
        w_res.found_value = w_tok[ENTRIES].found_value;
        unique case (w_tok[ENTRIES].req_type)
            REQ_ADD:    w_res.status = w_tok[ENTRIES].done ? ST_OK : ST_FULL;
            REQ_REMOVE,
            REQ_LOOKUP: w_res.status = w_tok[ENTRIES].done ? ST_OK : ST_NOT_FOUND;
            default:    w_res.status = ST_OK;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        if (w_in_acc) begin
            n_busy = 1'b1;
        end else if (w_exit) begin
            n_busy = 1'b0;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (w_out_take) begin
            n_out_valid = 1'b0;
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end
        end
        if (w_exit) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = w_res;
            end else begin
                n_pend_valid = 1'b1;
                n_pend       = w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `KVST_ASSERT_NOW(a_one_token, i_clk, i_rst_n,
        1'b1, $countones(w_act) <= 1, "multiple tokens in chain")
    `KVST_ASSERT_NOW(a_busy_tracks_chain, i_clk, i_rst_n,
        1'b1, r_busy == (w_act != '0), "busy flag out of step with chain")
    `KVST_ASSERT_NEXT(a_launch, i_clk, i_rst_n,
        w_in_acc, w_act[0], "accepted transaction did not enter chain")
    `KVST_ASSERT_NEXT(a_exit_frees, i_clk, i_rst_n,
        w_exit, !r_busy && r_out_valid, "exit did not produce a result")
    `KVST_ASSERT_NOW(a_pend_order, i_clk, i_rst_n,
        r_pend_valid, r_out_valid, "pending result with empty output")

endmodule

FILE: test/key_value_slot_table_checker.sv
// ----------------------------------------------------------------------------
// Key/value slot table checker
// Watches both channels, keeps its own slot table to predict each response
// and compares every response transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module key_value_slot_table_checker #(
    parameter int ENTRIES = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  kvst_pkg::t_req  i_in,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  kvst_pkg::t_resp i_out,
    output int              o_pending,
    output int              o_mismatches
);
    import kvst_pkg::*;

    logic             slot_used [ENTRIES];
    logic [KEY_W-1:0] slot_key  [ENTRIES];
    logic [VAL_W-1:0] slot_val  [ENTRIES];

    t_resp expected_resp [$];
    int    mismatch_cnt = 0;
    int    resp_idx = 0;

    assign o_mismatches = mismatch_cnt;

    function automatic int lowest_match(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == k) return i;
        end
        return ENTRIES;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i]) return i;
        end
        return ENTRIES;
    endfunction

    // Applies one request to the local table and returns its response.
    function automatic t_resp apply_request(t_req r);
        t_resp rsp;
        int    idx;
        rsp.status      = ST_OK;
        rsp.found_value = '0;
        case (r.req_type)
            REQ_ADD: begin
                idx = lowest_free();
                if (idx < ENTRIES) begin
                    slot_used[idx] = 1'b1;
                    slot_key[idx]  = r.key;
                    slot_val[idx]  = r.value;
                end else begin
                    rsp.status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                idx = lowest_match(r.key);
                if (idx < ENTRIES) begin
                    slot_used[idx] = 1'b0;
                    slot_key[idx]  = '0;
                    slot_val[idx]  = '0;
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            REQ_LOOKUP: begin
                idx = lowest_match(r.key);
                if (idx < ENTRIES) rsp.found_value = slot_val[idx];
                else rsp.status = ST_NOT_FOUND;
            end
            default: ;  // unused code: no effect
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_resp want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
                slot_val[i]  = '0;
            end
            expected_resp.delete();
        end else begin
            // retire before predicting: a response never belongs to a request
            // accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_resp.size() == 0) begin
                    report_mismatch($sformatf("response with none pending, status %0d value %h",
                                              i_out.status, i_out.found_value));
                end else begin
                    want = expected_resp.pop_front();
                    if (i_out.status !== want.status)
                        report_mismatch($sformatf("response %0d status %0d, want %0d",
                                                  resp_idx, i_out.status, want.status));
                    if (i_out.found_value !== want.found_value)
                        report_mismatch($sformatf("response %0d found_value %h, want %h",
                                                  resp_idx, i_out.found_value,
                                                  want.found_value));
                    resp_idx++;
                end
            end
            if (i_in_valid && i_in_ready)
                expected_resp.push_back(apply_request(i_in));
        end
        o_pending <= expected_resp.size();
    end

endmodule

FILE: test/key_value_slot_table_tb.sv
// ----------------------------------------------------------------------------
// Key/value slot table testbench
// Directed corner requests, then random add/remove/lookup traffic that
// alternately fills and drains the table, under four idle/stall mixes.
// ----------------------------------------------------------------------------
module key_value_slot_table_tb;
    import kvst_pkg::*;

    localparam int ENTRIES         = 64;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int BIAS_RUN        = 150;
    localparam int POOL_SIZE       = 12;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_req  in_req    = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_resp out_resp;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int pending;
    int mismatches;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) out_ready <= ($urandom_range(99) >= rcv_stall_pct);

    key_value_slot_table #(
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_resp)
    );

    key_value_slot_table_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_req),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_resp),
        .o_pending   (pending),
        .o_mismatches(mismatches)
    );

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic t_req make_req(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                      logic [VAL_W-1:0] v);
        t_req r;
        r.req_type = op;
        r.key      = k;
        r.value    = v;
        return r;
    endfunction

    // Fill runs favor adds so the table reaches full; drain runs favor removes.
    function automatic t_req random_req(bit filling);
        int               pick;
        logic [REQ_W-1:0] op;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(99);
        if (filling)
            op = (pick < 60) ? REQ_ADD : (pick < 72) ? REQ_REMOVE :
                 (pick < 95) ? REQ_LOOKUP : REQ_UNUSED;
        else
            op = (pick < 12) ? REQ_ADD : (pick < 67) ? REQ_REMOVE :
                 (pick < 95) ? REQ_LOOKUP : REQ_UNUSED;
        // mostly pooled keys so removes and lookups hit, some fully random
        k = ($urandom_range(4) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(POOL_SIZE-1)];
        return make_req(op, k, VAL_W'($urandom));
    endfunction

    task automatic send_req(t_req r);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (!in_ready);
    endtask

    // Holds off the sender until every pending response has come back.
    task automatic drain_pending();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int n;
        n = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, unused code, duplicates and lowest-slot ordering
        send_req(make_req(REQ_LOOKUP, 16'h0000, 16'h0000));
        send_req(make_req(REQ_REMOVE, 16'hFFFF, 16'h0000));
        send_req(make_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF));
        send_req(make_req(REQ_ADD,    16'h0000, 16'hFFFF));
        send_req(make_req(REQ_ADD,    16'hFFFF, 16'h0000));
        send_req(make_req(REQ_ADD,    16'hFFFF, 16'hA5A5));
        send_req(make_req(REQ_LOOKUP, 16'hFFFF, 16'h0000));
        send_req(make_req(REQ_LOOKUP, 16'h0000, 16'hFFFF));
        send_req(make_req(REQ_REMOVE, 16'hFFFF, 16'h0000));
        send_req(make_req(REQ_LOOKUP, 16'hFFFF, 16'h0000));
        send_req(make_req(REQ_ADD,    16'h1234, 16'h5678));
        send_req(make_req(REQ_LOOKUP, 16'h1234, 16'hFFFF));
        send_req(make_req(REQ_REMOVE, 16'h0000, 16'hFFFF));
        send_req(make_req(REQ_REMOVE, 16'h0000, 16'h0000));
        send_req(make_req(REQ_UNUSED, 16'h0000, 16'h0000));
        send_req(make_req(REQ_REMOVE, 16'hFFFF, 16'h0000));
        send_req(make_req(REQ_REMOVE, 16'h1234, 16'h0000));
        send_req(make_req(REQ_LOOKUP, 16'hFFFF, 16'h0000));
        drain_pending();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 63; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 63; end
                default: begin snd_idle_pct = 26; rcv_stall_pct = 26; end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                send_req(random_req(((n / BIAS_RUN) % 2) == 0));
                n++;
            end
        end

        drain_pending();
        repeat (2 * ENTRIES + 8) @(posedge clk);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

FILE: key_value_slot_table.f
+incdir+sv
sv/kvst_pkg.sv
sv/kvst_cell.sv
sv/key_value_slot_table.sv
test/key_value_slot_table_checker.sv
test/key_value_slot_table_tb.sv
